>>> rtl/bfst_pkg.sv
package bfst_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int VAL_W        = 31;
    localparam int CMD_W        = 2;
    localparam int STAT_W       = 2;
    localparam int CNT_OUT_W    = 7;
    localparam int WORD_W       = VAL_W + 1;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_MISS = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH,
        ST_DONE
    } t_state;

    // control from the sequencer to the slot evaluator
    typedef struct packed {
        logic start;
        logic rd_vld;
    } t_scan_ctl;

    // hit flags gathered over one scan
    typedef struct packed {
        logic free_hit;
        logic match_hit;
        logic best_hit;
    } t_scan_res;

endpackage

>>> rtl/bfst_ram.sv
module bfst_ram #(
    parameter int WIDTH = bfst_pkg::WORD_W,
    parameter int DEPTH = bfst_pkg::CAPACITY_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/bfst_match.sv
module bfst_match #(
    parameter int CAPACITY = bfst_pkg::CAPACITY_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  bfst_pkg::t_scan_ctl               i_ctl,
    input  logic [$clog2(CAPACITY)-1:0]       i_idx,
    input  logic [bfst_pkg::WORD_W-1:0]       i_word,
    input  logic [bfst_pkg::VAL_W-1:0]        i_amount,
    output bfst_pkg::t_scan_res               o_res,
    output logic [$clog2(CAPACITY)-1:0]       o_free_idx,
    output logic [$clog2(CAPACITY)-1:0]       o_match_idx,
    output logic [bfst_pkg::VAL_W-1:0]        o_best_val
);

    localparam int AW = $clog2(CAPACITY);

    bfst_pkg::t_scan_res          r_res, n_res;
    logic [AW-1:0]                r_free_idx, n_free_idx;
    logic [AW-1:0]                r_match_idx, n_match_idx;
    logic [bfst_pkg::VAL_W-1:0]   r_best_val, n_best_val;

    logic                         w_valid;
    logic [bfst_pkg::VAL_W-1:0]   w_val;

    assign w_valid = i_word[bfst_pkg::WORD_W-1];
    assign w_val   = i_word[bfst_pkg::VAL_W-1:0];

    always_comb begin
        n_res       = r_res;
        n_free_idx  = r_free_idx;
        n_match_idx = r_match_idx;
        n_best_val  = r_best_val;
        if (i_ctl.start) begin
            n_res = '0;
        end else if (i_ctl.rd_vld) begin
            // keep the lowest free slot, the lowest matching slot and the smallest value not below the amount
            if (!w_valid && !r_res.free_hit) begin
                n_res.free_hit = 1'b1;
                n_free_idx     = i_idx;
            end
            if (w_valid && (w_val == i_amount) && !r_res.match_hit) begin
                n_res.match_hit = 1'b1;
                n_match_idx     = i_idx;
            end
            if (w_valid && (w_val >= i_amount) && (!r_res.best_hit || w_val < r_best_val)) begin
                n_res.best_hit = 1'b1;
                n_best_val     = w_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res <= '0;
        end else begin
            r_res <= n_res;
        end
        r_free_idx  <= n_free_idx;
        r_match_idx <= n_match_idx;
        r_best_val  <= n_best_val;
    end

    assign o_res       = r_res;
    assign o_free_idx  = r_free_idx;
    assign o_match_idx = r_match_idx;
    assign o_best_val  = r_best_val;

endmodule

>>> rtl/best_fit_free_space_table.sv
// Best-fit free-space table: a multiset of up to CAPACITY 31-bit values held
// in one memory word per slot (valid bit and value). Each command (insert,
// remove one instance, best-fit query) reads every slot once through the
// memory's single read port, then writes at most one slot and returns one
// result holding status, the found value and the entry count. The result passes
// through the SCAN, DRAIN, FINISH and DONE states into the output register, and a
// new command is accepted only after that, so a command occupies the block for
// the whole scan of all slots; a result not yet taken from the output holds
// off the next one. After reset the block clears all CAPACITY slots, one per
// cycle, before it accepts the first command. Insert goes to the lowest free
// slot, remove clears the lowest matching slot.
module best_fit_free_space_table #(
    parameter int CAPACITY = bfst_pkg::CAPACITY_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [30:0] amount, [31] zero
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] cmd
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // [30:0] found_value, [37:31] entry_count, [39:38] zero
    output logic [1:0]  o_m_axis_tuser    // [1:0] status
);

    localparam int AW    = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int VW    = bfst_pkg::VAL_W;
    localparam int OW    = bfst_pkg::CNT_OUT_W;
    localparam logic [AW-1:0] LAST_ADDR = AW'(CAPACITY - 1);

    bfst_pkg::t_state             r_state, n_state;
    logic [AW-1:0]                r_addr, n_addr;
    logic [bfst_pkg::CMD_W-1:0]   r_cmd;
    logic [VW-1:0]                r_amount;
    logic [CNT_W-1:0]             r_count, n_count;
    logic                         r_rd_vld;
    logic [AW-1:0]                r_rd_idx;

    logic [bfst_pkg::STAT_W-1:0]  r_res_status, n_res_status;
    logic [VW-1:0]                r_res_found, n_res_found;
    logic [OW-1:0]                r_res_count;

    logic                         r_out_valid;
    logic [bfst_pkg::STAT_W-1:0]  r_out_status;
    logic [VW-1:0]                r_out_found;
    logic [OW-1:0]                r_out_count;

    logic                         w_accept;
    logic                         w_load;
    logic                         w_we;
    logic [AW-1:0]                w_waddr;
    logic [bfst_pkg::WORD_W-1:0]  w_wdata;
    logic [bfst_pkg::WORD_W-1:0]  w_rdata;
    logic [CNT_W+OW-1:0]          w_count_ext;

    bfst_pkg::t_scan_ctl          w_ctl;
    bfst_pkg::t_scan_res          w_res;
    logic [AW-1:0]                w_free_idx;
    logic [AW-1:0]                w_match_idx;
    logic [VW-1:0]                w_best_val;

    bfst_ram #(
        .WIDTH(bfst_pkg::WORD_W),
        .DEPTH(CAPACITY)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(r_addr),
        .o_rdata(w_rdata)
    );

    assign w_ctl.start  = w_accept;
    assign w_ctl.rd_vld = r_rd_vld;

    bfst_match #(
        .CAPACITY(CAPACITY)
    ) u_match (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_idx      (r_rd_idx),
        .i_word     (w_rdata),
        .i_amount   (r_amount),
        .o_res      (w_res),
        .o_free_idx (w_free_idx),
        .o_match_idx(w_match_idx),
        .o_best_val (w_best_val)
    );

    assign o_s_axis_tready = (r_state == bfst_pkg::ST_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_load          = (r_state == bfst_pkg::ST_DONE) && (!r_out_valid || i_m_axis_tready);
    assign w_count_ext     = {{OW{1'b0}}, n_count};

    always_comb begin
        n_state      = r_state;
        n_addr       = r_addr;
        n_count      = r_count;
        n_res_status = r_res_status;
        n_res_found  = r_res_found;
        w_we         = 1'b0;
        w_waddr      = r_addr;
        w_wdata      = '0;
        case (r_state)
            bfst_pkg::ST_CLEAR: begin
                w_we = 1'b1;
                if (r_addr == LAST_ADDR) begin
                    n_addr  = '0;
                    n_state = bfst_pkg::ST_IDLE;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            bfst_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_addr  = '0;
                    n_state = bfst_pkg::ST_SCAN;
                end
            end
            bfst_pkg::ST_SCAN: begin
                if (r_addr == LAST_ADDR) begin
                    n_addr  = '0;
                    n_state = bfst_pkg::ST_DRAIN;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            bfst_pkg::ST_DRAIN: begin
                n_state = bfst_pkg::ST_FINISH;
            end
            bfst_pkg::ST_FINISH: begin
                n_res_found  = '0;
                n_res_status = bfst_pkg::STAT_MISS;
                case (r_cmd)
                    bfst_pkg::CMD_INSERT: begin
                        if (w_res.free_hit) begin
                            w_we         = 1'b1;
                            w_waddr      = w_free_idx;
                            w_wdata      = {1'b1, r_amount};
                            n_count      = r_count + 1'b1;
                            n_res_status = bfst_pkg::STAT_OK;
                        end else begin
                            n_res_status = bfst_pkg::STAT_FULL;
                        end
                    end
                    bfst_pkg::CMD_REMOVE: begin
                        if (w_res.match_hit) begin
                            w_we         = 1'b1;
                            w_waddr      = w_match_idx;
                            n_count      = r_count - 1'b1;
                            n_res_status = bfst_pkg::STAT_OK;
                        end
                    end
                    bfst_pkg::CMD_QUERY: begin
                        if (w_res.best_hit) begin
                            n_res_status = bfst_pkg::STAT_OK;
                            n_res_found  = w_best_val;
                        end
                    end
                    default: begin
                        n_res_status = bfst_pkg::STAT_MISS;
                    end
                endcase
                n_state = bfst_pkg::ST_DONE;
            end
            bfst_pkg::ST_DONE: begin
                if (w_load) begin
                    n_state = bfst_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bfst_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bfst_pkg::ST_CLEAR;
            r_addr      <= '0;
            r_count     <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_addr   <= n_addr;
            r_count  <= n_count;
            r_rd_vld <= (r_state == bfst_pkg::ST_SCAN);
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_addr;
        if (w_accept) begin
            r_cmd    <= i_s_axis_tuser;
            r_amount <= i_s_axis_tdata[VW-1:0];
        end
        if (r_state == bfst_pkg::ST_FINISH) begin
            r_res_status <= n_res_status;
            r_res_found  <= n_res_found;
            r_res_count  <= w_count_ext[OW-1:0];
        end
        if (w_load) begin
            r_out_status <= r_res_status;
            r_out_found  <= r_res_found;
            r_out_count  <= r_res_count;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tdata  = {2'b00, r_out_count, r_out_found};

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count exceeds capacity");

    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == bfst_pkg::ST_CLEAR || r_state == bfst_pkg::ST_FINISH))
        else $error("memory write outside clear or finish");

    a_count_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(r_count)) |-> ($past(r_state) == bfst_pkg::ST_FINISH))
        else $error("entry count changed outside finish");
`endif

endmodule

>>> bench/best_fit_free_space_table_tb.sv
module best_fit_free_space_table_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY = bfst_pkg::CAPACITY_DEF;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int RANDOM_PER_PHASE = 285;
    localparam int MAX_PRINTED = 20;
    localparam logic [bfst_pkg::CMD_W-1:0] CMD_NOP = 2'd3;
    localparam logic [bfst_pkg::VAL_W-1:0] AMOUNT_MAX = '1;

    typedef struct packed {
        logic [bfst_pkg::STAT_W-1:0]    status;
        logic [bfst_pkg::VAL_W-1:0]     found_value;
        logic [bfst_pkg::CNT_OUT_W-1:0] entry_count;
    } t_fit_result;

    class free_space_scoreboard;
        logic [bfst_pkg::VAL_W-1:0] slot_value [bfst_pkg::CAPACITY_DEF];
        bit                         slot_valid [bfst_pkg::CAPACITY_DEF];
        int                         stored_count;
        t_fit_result                pending_results[$];
        int                         mismatches;
        int                         checked;
        int                         full_hits;
        int                         fit_hits;
        int                         peak_count;
        int                         cmd_seen[4];

        function new();
            foreach (slot_valid[i]) begin
                slot_valid[i] = 1'b0;
                slot_value[i] = '0;
            end
            stored_count = 0;
            mismatches   = 0;
            checked      = 0;
            full_hits    = 0;
            fit_hits     = 0;
            peak_count   = 0;
            foreach (cmd_seen[i]) cmd_seen[i] = 0;
        endfunction

        function int pending_count();
            return pending_results.size();
        endfunction

        // advance the table copy by one accepted command and queue its result
        function void note_command(logic [bfst_pkg::CMD_W-1:0] cmd,
                                   logic [bfst_pkg::VAL_W-1:0] amount);
            t_fit_result res;
            bit          hit;
            res.status      = bfst_pkg::STAT_MISS;
            res.found_value = '0;
            hit             = 1'b0;
            cmd_seen[cmd]++;
            case (cmd)
                bfst_pkg::CMD_INSERT: begin
                    res.status = bfst_pkg::STAT_FULL;
                    for (int i = 0; i < bfst_pkg::CAPACITY_DEF && !hit; i++) begin
                        if (!slot_valid[i]) begin
                            slot_valid[i] = 1'b1;
                            slot_value[i] = amount;
                            stored_count++;
                            hit        = 1'b1;
                            res.status = bfst_pkg::STAT_OK;
                        end
                    end
                    if (!hit) full_hits++;
                end
                bfst_pkg::CMD_REMOVE: begin
                    for (int i = 0; i < bfst_pkg::CAPACITY_DEF && !hit; i++) begin
                        if (slot_valid[i] && slot_value[i] == amount) begin
                            slot_valid[i] = 1'b0;
                            stored_count--;
                            hit        = 1'b1;
                            res.status = bfst_pkg::STAT_OK;
                        end
                    end
                end
                bfst_pkg::CMD_QUERY: begin
                    for (int i = 0; i < bfst_pkg::CAPACITY_DEF; i++) begin
                        if (slot_valid[i] && slot_value[i] >= amount &&
                            (!hit || slot_value[i] < res.found_value)) begin
                            res.found_value = slot_value[i];
                            hit             = 1'b1;
                        end
                    end
                    if (hit) begin
                        res.status = bfst_pkg::STAT_OK;
                        fit_hits++;
                    end
                end
                default: ;
            endcase
            res.entry_count = bfst_pkg::CNT_OUT_W'(stored_count);
            if (stored_count > peak_count) peak_count = stored_count;
            pending_results.push_back(res);
        endfunction

        // random value currently held in the table; call only when not empty
        function logic [bfst_pkg::VAL_W-1:0] any_stored();
            int skip;
            skip = int'($urandom_range(0, stored_count - 1));
            foreach (slot_valid[i]) begin
                if (slot_valid[i]) begin
                    if (skip == 0) return slot_value[i];
                    skip--;
                end
            end
            return '0;
        endfunction

        task report_mismatch(string what);
            mismatches++;
            if (mismatches <= MAX_PRINTED) $display("[%0t] mismatch: %s", $realtime, what);
        endtask

        task check_result(t_fit_result got);
            t_fit_result want;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result with no command outstanding (status %0d)",
                                          got.status));
            end else begin
                want = pending_results.pop_front();
                checked++;
                if (got.status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              got.status, want.status));
                if (got.found_value !== want.found_value)
                    report_mismatch($sformatf("found_value 0x%08h, expected 0x%08h",
                                              got.found_value, want.found_value));
                if (got.entry_count !== want.entry_count)
                    report_mismatch($sformatf("entry_count %0d, expected %0d",
                                              got.entry_count, want.entry_count));
            end
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata = '0;   // [30:0] amount, [31] zero
    logic [1:0]  i_s_axis_tuser = '0;   // [1:0] cmd
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [39:0] o_m_axis_tdata;        // [30:0] found_value, [37:31] entry_count, [39:38] zero
    logic [1:0]  o_m_axis_tuser;        // [1:0] status

    free_space_scoreboard fit_board;
    int send_idle_pct = 14;
    int recv_idle_pct = 85;
    int cycle_count = 0;
    bit growing = 1'b1;

    best_fit_free_space_table #(.CAPACITY(CAPACITY)) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tuser (o_m_axis_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, fit_board.pending_count());
            $display("** best_fit_free_space_table: FAILED **");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            fit_board.check_result('{status:      o_m_axis_tuser,
                                     found_value: o_m_axis_tdata[30:0],
                                     entry_count: o_m_axis_tdata[37:31]});
    end

    // hold the command until the transaction completes; leave tvalid high afterwards
    task automatic send_command(input logic [bfst_pkg::CMD_W-1:0] cmd,
                                input logic [bfst_pkg::VAL_W-1:0] amount);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {1'b0, amount};
        i_s_axis_tuser  <= cmd;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        fit_board.note_command(cmd, amount);
    endtask

    function automatic logic [bfst_pkg::VAL_W-1:0] random_amount();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 4) return bfst_pkg::VAL_W'($urandom_range(0, 15));
        if (roll == 4) begin
            case ($urandom_range(0, 3))
                0: return '0;
                1: return bfst_pkg::VAL_W'(1);
                2: return AMOUNT_MAX - 1'b1;
                default: return AMOUNT_MAX;
            endcase
        end
        return bfst_pkg::VAL_W'($urandom);
    endfunction

    // fill toward full, then drain toward empty, so both ends of the table are hit
    task automatic pick_command(output logic [bfst_pkg::CMD_W-1:0] cmd,
                                output logic [bfst_pkg::VAL_W-1:0] amount);
        int roll;
        roll = $urandom_range(0, 99);
        if (growing)
            cmd = roll < 60 ? bfst_pkg::CMD_INSERT : roll < 75 ? bfst_pkg::CMD_REMOVE :
                  roll < 96 ? bfst_pkg::CMD_QUERY : CMD_NOP;
        else
            cmd = roll < 15 ? bfst_pkg::CMD_INSERT : roll < 65 ? bfst_pkg::CMD_REMOVE :
                  roll < 96 ? bfst_pkg::CMD_QUERY : CMD_NOP;
        amount = random_amount();
        if (fit_board.stored_count > 0) begin
            if (cmd == bfst_pkg::CMD_REMOVE && $urandom_range(0, 3) != 0) begin
                amount = fit_board.any_stored();
            end else if (cmd == bfst_pkg::CMD_QUERY && $urandom_range(0, 1) != 0) begin
                amount = fit_board.any_stored();
                case ($urandom_range(0, 2))
                    0: amount = amount - 1'b1;
                    1: amount = amount + 1'b1;
                    default: ;
                endcase
            end
        end
        if (growing && fit_board.stored_count == CAPACITY && $urandom_range(0, 3) == 0)
            growing = 1'b0;
        else if (!growing && fit_board.stored_count == 0 && $urandom_range(0, 2) == 0)
            growing = 1'b1;
    endtask

    initial begin
        logic [bfst_pkg::CMD_W-1:0] cmd;
        logic [bfst_pkg::VAL_W-1:0] amount;
        fit_board = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty table, no-op code, stored zero, extremes and duplicates
        send_command(bfst_pkg::CMD_QUERY,  '0);
        send_command(bfst_pkg::CMD_REMOVE, bfst_pkg::VAL_W'(5));
        send_command(CMD_NOP,              AMOUNT_MAX);
        send_command(bfst_pkg::CMD_INSERT, '0);
        send_command(bfst_pkg::CMD_QUERY,  '0);
        send_command(bfst_pkg::CMD_QUERY,  bfst_pkg::VAL_W'(1));
        send_command(bfst_pkg::CMD_INSERT, AMOUNT_MAX);
        send_command(bfst_pkg::CMD_QUERY,  bfst_pkg::VAL_W'(1));
        send_command(bfst_pkg::CMD_QUERY,  AMOUNT_MAX);
        send_command(bfst_pkg::CMD_INSERT, bfst_pkg::VAL_W'(1000));
        send_command(bfst_pkg::CMD_INSERT, bfst_pkg::VAL_W'(1000));
        send_command(bfst_pkg::CMD_QUERY,  bfst_pkg::VAL_W'(999));
        send_command(bfst_pkg::CMD_QUERY,  bfst_pkg::VAL_W'(1001));
        send_command(bfst_pkg::CMD_REMOVE, bfst_pkg::VAL_W'(1000));
        send_command(bfst_pkg::CMD_QUERY,  bfst_pkg::VAL_W'(1000));
        send_command(bfst_pkg::CMD_REMOVE, bfst_pkg::VAL_W'(1000));
        send_command(bfst_pkg::CMD_REMOVE, bfst_pkg::VAL_W'(1000));
        send_command(bfst_pkg::CMD_INSERT, 31'h5555_5555);
        send_command(bfst_pkg::CMD_INSERT, 31'h2AAA_AAAA);
        send_command(bfst_pkg::CMD_QUERY,  31'h2AAA_AAAB);
        send_command(CMD_NOP,              '0);
        send_command(bfst_pkg::CMD_REMOVE, '0);
        send_command(bfst_pkg::CMD_REMOVE, AMOUNT_MAX);
        send_command(bfst_pkg::CMD_QUERY,  '0);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin send_idle_pct = 14; recv_idle_pct = 85; end
                1: begin send_idle_pct = 85; recv_idle_pct = 14; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            repeat (RANDOM_PER_PHASE) begin
                pick_command(cmd, amount);
                send_command(cmd, amount);
            end
        end
        i_s_axis_tvalid <= 1'b0;

        while (fit_board.pending_count() != 0) @(posedge i_clk);
        repeat (CAPACITY + 8) @(posedge i_clk);

        $display("commands: %0d insert, %0d remove, %0d query, %0d no-op; %0d results checked",
                 fit_board.cmd_seen[bfst_pkg::CMD_INSERT],
                 fit_board.cmd_seen[bfst_pkg::CMD_REMOVE],
                 fit_board.cmd_seen[bfst_pkg::CMD_QUERY],
                 fit_board.cmd_seen[CMD_NOP], fit_board.checked);
        $display("inserts refused as full: %0d, queries with a fit: %0d, peak occupancy %0d/%0d",
                 fit_board.full_hits, fit_board.fit_hits, fit_board.peak_count, CAPACITY);
        if (fit_board.mismatches == 0) begin
            $display("** best_fit_free_space_table: PASSED **");
        end else begin
            $display("%0d mismatches", fit_board.mismatches);
            $display("** best_fit_free_space_table: FAILED **");
        end
        $finish;
    end

endmodule
